/* rtl/kli_pkg.sv */
// kli_pkg: shared types and constants of the keyframe linear interpolator.
// Beat payloads, key table entry, status codes, sequencer states.
// No dependencies.
`timescale 1ns / 1ps

package kli_pkg;

  localparam int unsigned VAL_W     = 32;  // time and value width, Q16.16
  localparam int unsigned FRAC_W    = 16;
  localparam int unsigned IDX_W     = 6;   // key_index and segment width
  localparam int unsigned CFG_W     = 7;   // key_count width
  localparam int unsigned DIV_W     = VAL_W + FRAC_W;  // factor magnitude width
  localparam int unsigned MUL_A_W   = 24;  // factor slice fed to the multiplier
  localparam int unsigned PROD_W    = MUL_A_W + VAL_W;
  localparam int unsigned Q_W       = 49;  // scaled product magnitude
  localparam int unsigned NUM_COMP  = 3;

  localparam logic [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

  typedef enum logic [0:0] {
    OP_LOAD   = 1'b0,
    OP_SAMPLE = 1'b1
  } kli_op_e;

  typedef enum logic [1:0] {
    STS_INTERP   = 2'd0,
    STS_SINGLE   = 2'd1,
    STS_ZERO_LEN = 2'd2,
    STS_SAT      = 2'd3
  } kli_status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SINGLE,
    S_SRCH,
    S_FETCH0,
    S_FETCH1,
    S_PREP,
    S_DIV_GO,
    S_DIV_WAIT,
    S_DELTA,
    S_MUL_HI,
    S_MUL_LO,
    S_SUM,
    S_APPLY,
    S_EMIT
  } kli_state_e;

  typedef enum logic [2:0] {
    LS_IDLE,
    LS_DELTA,
    LS_MUL_HI,
    LS_MUL_LO,
    LS_SUM,
    LS_APPLY
  } kli_lerp_step_e;

  typedef struct packed {
    kli_op_e                   op;
    logic [IDX_W-1:0]          key_index;
    logic [VAL_W-1:0]          key_time;
    logic signed [VAL_W-1:0]   key_x;
    logic signed [VAL_W-1:0]   key_y;
    logic signed [VAL_W-1:0]   key_z;
    logic [VAL_W-1:0]          sample_time;
  } kli_in_t;

  typedef struct packed {
    logic signed [VAL_W-1:0]   out_x;
    logic signed [VAL_W-1:0]   out_y;
    logic signed [VAL_W-1:0]   out_z;
    logic [IDX_W-1:0]          segment;
    kli_status_e               status;
  } kli_out_t;

  typedef struct packed {
    logic [VAL_W-1:0]          key_time;
    logic signed [VAL_W-1:0]   key_x;
    logic signed [VAL_W-1:0]   key_y;
    logic signed [VAL_W-1:0]   key_z;
  } kli_key_t;

endpackage

/* rtl/kli_stream_if.sv */
// kli_stream_if: valid/ready channel carrying one payload per beat.
// Payload type is set at instantiation (kli_pkg beat types).
`timescale 1ns / 1ps

interface kli_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

/* rtl/kli_key_mem.sv */
// kli_key_mem: key table, one write port and one registered read port.
// Depends on kli_pkg (kli_key_t).
`timescale 1ns / 1ps

module kli_key_mem #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = 6
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [AW-1:0]     waddr_i,
  input  kli_pkg::kli_key_t wdata_i,
  input  logic [AW-1:0]     raddr_i,
  output kli_pkg::kli_key_t rdata_o
);

  kli_pkg::kli_key_t mem_q [DEPTH];
  kli_pkg::kli_key_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/kli_divider.sv */
// kli_divider: restoring unsigned divider, one quotient bit per cycle.
// Depends on kli_pkg (DIV_W, VAL_W).
`timescale 1ns / 1ps

module kli_divider (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [kli_pkg::DIV_W-1:0]   dividend_i,
  input  logic [kli_pkg::VAL_W-1:0]   divisor_i,
  output logic                        busy_o,
  output logic [kli_pkg::DIV_W-1:0]   quotient_o
);

  localparam int unsigned DW    = kli_pkg::DIV_W;
  localparam int unsigned VW    = kli_pkg::VAL_W;
  localparam int unsigned CNT_W = $clog2(DW + 1);

  logic [CNT_W-1:0] cnt_q;
  logic [DW-1:0]    dq_q;
  logic [VW-1:0]    rem_q;
  logic [VW-1:0]    dvs_q;
  logic [VW:0]      trial;
  logic [VW:0]      diff;
  logic             fits;

  assign trial = {rem_q, dq_q[DW-1]};
  assign diff  = trial - {1'b0, dvs_q};
  assign fits  = trial >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (start_i) begin
      cnt_q <= CNT_W'(DW);
    end else if (cnt_q != '0) begin
      cnt_q <= cnt_q - CNT_W'(1);
    end
  end

  // shift dividend bits out at the top, quotient bits in at the bottom
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dq_q  <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (cnt_q != '0) begin
      rem_q <= fits ? diff[VW-1:0] : trial[VW-1:0];
      dq_q  <= {dq_q[DW-2:0], fits};
    end
  end

  assign busy_o     = cnt_q != '0;
  assign quotient_o = dq_q;

endmodule

/* rtl/kli_lerp_unit.sv */
// kli_lerp_unit: shared 24x32 multiplier and accumulate path; one component
// at a time, stepped by the sequencer. Depends on kli_pkg.
`timescale 1ns / 1ps

module kli_lerp_unit (
  input  logic                              clk_i,
  input  kli_pkg::kli_lerp_step_e           step_i,
  input  logic signed [kli_pkg::VAL_W-1:0]  start_i,
  input  logic signed [kli_pkg::VAL_W-1:0]  end_i,
  input  logic [kli_pkg::DIV_W-1:0]         factor_i,
  input  logic                              fneg_i,
  output logic signed [kli_pkg::VAL_W-1:0]  res_o,
  output logic                              sat_o
);

  localparam int unsigned VW       = kli_pkg::VAL_W;
  localparam int unsigned AW_M     = kli_pkg::MUL_A_W;
  localparam int unsigned PW       = kli_pkg::PROD_W;
  localparam int unsigned QW       = kli_pkg::Q_W;
  localparam int unsigned FW       = kli_pkg::FRAC_W;
  localparam int unsigned HI_SHIFT = AW_M - FW;
  localparam int unsigned SAT_BIT  = QW - HI_SHIFT - 1;
  localparam int unsigned RW       = QW + 2;

  logic [VW-1:0]          md_q;
  logic                   neg_q;
  logic [PW-1:0]          a_q;
  logic [PW-1:0]          b_q;
  logic                   ovf_q;
  logic [QW-1:0]          q_q;

  logic                   dneg;
  logic signed [VW:0]     start_x;
  logic signed [VW:0]     end_x;
  logic signed [VW:0]     diff;
  logic [AW_M-1:0]        mul_a;
  logic [PW-1:0]          prod;
  logic [QW-1:0]          q_d;
  logic signed [RW-1:0]   sx;
  logic signed [RW-1:0]   qx;
  logic signed [RW-1:0]   r;
  logic                   in_range;

  assign start_x = (VW + 1)'(start_i);
  assign end_x   = (VW + 1)'(end_i);
  assign dneg    = end_i < start_i;
  assign diff    = dneg ? start_x - end_x : end_x - start_x;

  // the one multiplier: high factor slice first, then the low slice
  assign mul_a = (step_i == kli_pkg::LS_MUL_HI) ? factor_i[kli_pkg::DIV_W-1:AW_M]
                                                 : factor_i[AW_M-1:0];
  assign prod  = mul_a * md_q;

  // floor(factor*delta / 2^16); round toward minus infinity on negative results
  assign q_d = {a_q[SAT_BIT:0], {HI_SHIFT{1'b0}}} + QW'(b_q[PW-1:FW])
             + QW'(neg_q && (b_q[FW-1:0] != '0));

  always_ff @(posedge clk_i) begin
    case (step_i)
      kli_pkg::LS_DELTA: begin
        md_q  <= diff[VW-1:0];
        neg_q <= fneg_i ^ dneg;
      end
      kli_pkg::LS_MUL_HI: a_q <= prod;
      kli_pkg::LS_MUL_LO: b_q <= prod;
      kli_pkg::LS_SUM: begin
        ovf_q <= a_q[PW-1:SAT_BIT] != '0;
        q_q   <= q_d;
      end
      default: ;
    endcase
  end

  assign sx       = RW'(start_i);
  assign qx       = RW'(q_q);
  assign r        = neg_q ? sx - qx : sx + qx;
  assign in_range = (r[RW-1:VW-1] == '0) || (r[RW-1:VW-1] == '1);

  always_comb begin
    if (ovf_q) begin
      res_o = neg_q ? kli_pkg::VAL_MIN : kli_pkg::VAL_MAX;
      sat_o = 1'b1;
    end else if (!in_range) begin
      res_o = r[RW-1] ? kli_pkg::VAL_MIN : kli_pkg::VAL_MAX;
      sat_o = 1'b1;
    end else begin
      res_o = r[VW-1:0];
      sat_o = 1'b0;
    end
  end

endmodule

/* rtl/keyframe_linear_interpolator.sv */
// keyframe_linear_interpolator: key table plus a sequencer driving one divider
// and one shared multiplier. Depends on kli_pkg, kli_stream_if, kli_key_mem,
// kli_divider, kli_lerp_unit.
//
// Load beats (op = 0) write one key (time, x, y, z) into slot key_index and
// return nothing; slots at or beyond MAX_KEYS are dropped.
// Sample beats (op = 1) return one result beat. With one key in use the value
// of slot 0 is copied into the result registers and from them into the output
// register. Otherwise the block scans the key times from slot 1 upward, one
// key per cycle, for the first key later than sample_time, fetches the
// segment's two keys, forms the Q32.16 factor in a restoring divider at one
// quotient bit per cycle, and runs the three components one after another
// through a shared 24x32 multiplier, each in the steps delta, high product,
// low product, sum and apply. A zero-length segment skips the divider.
// The input side is ready only while the sequencer is idle. The result sits in
// an output register, so the next beat is taken while a result waits. The key
// table has no reset: sample only keys that were loaded. Write key_count only
// while the block is idle.
`timescale 1ns / 1ps

module keyframe_linear_interpolator #(
  parameter int unsigned MAX_KEYS = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [kli_pkg::CFG_W-1:0]     cfg_wdata_i,
  kli_stream_if.sink                    in_i,
  kli_stream_if.source                  out_o
);

  localparam int unsigned AW = $clog2(MAX_KEYS);
  localparam int unsigned CW = $clog2(MAX_KEYS + 1);
  localparam logic [1:0]  LAST_COMP = 2'(kli_pkg::NUM_COMP - 1);

  kli_pkg::kli_state_e      state_q, state_d;
  logic [kli_pkg::CFG_W-1:0] key_count_q;
  logic [CW-1:0]            n_q, n_eff;
  logic [AW-1:0]            addr_q, addr_d, seg_q;
  logic [kli_pkg::VAL_W-1:0] t_q, t0_q, t1_q, num_mag_q, den_mag_q;
  logic                     fneg_q;
  logic [1:0]               comp_q;
  logic [kli_pkg::DIV_W-1:0] mf_q;
  logic signed [kli_pkg::VAL_W-1:0] start_q [kli_pkg::NUM_COMP];
  logic signed [kli_pkg::VAL_W-1:0] end_q   [kli_pkg::NUM_COMP];
  logic signed [kli_pkg::VAL_W-1:0] res_q   [kli_pkg::NUM_COMP];
  kli_pkg::kli_status_e     status_q;
  kli_pkg::kli_out_t        out_q;
  logic                     out_valid_q;

  logic                     in_ready, in_fire, sample_fire, load_we;
  logic                     hit, last, den_zero, out_free;
  logic                     div_start, div_busy;
  logic [kli_pkg::DIV_W-1:0] quotient;
  kli_pkg::kli_lerp_step_e  lerp_step;
  logic signed [kli_pkg::VAL_W-1:0] lerp_res;
  logic                     lerp_sat;
  kli_pkg::kli_key_t        wdata, rdata;

  // ---------------------------------------------------------------- handshake
  assign in_ready    = state_q == kli_pkg::S_IDLE;
  assign in_i.ready  = in_ready;
  assign in_fire     = in_i.valid && in_ready;
  assign sample_fire = in_fire && (in_i.payload.op == kli_pkg::OP_SAMPLE);
  assign load_we     = in_fire && (in_i.payload.op == kli_pkg::OP_LOAD)
                       && (32'(in_i.payload.key_index) < MAX_KEYS);
  assign out_free    = !out_valid_q || out_o.ready;

  // keys in use: zero counts as one, clamp at the table depth
  always_comb begin
    if (key_count_q == '0) begin
      n_eff = CW'(1);
    end else if (32'(key_count_q) > MAX_KEYS) begin
      n_eff = CW'(MAX_KEYS);
    end else begin
      n_eff = CW'(key_count_q);
    end
  end

  // ---------------------------------------------------------------- key table
  assign wdata.key_time = in_i.payload.key_time;
  assign wdata.key_x    = in_i.payload.key_x;
  assign wdata.key_y    = in_i.payload.key_y;
  assign wdata.key_z    = in_i.payload.key_z;

  // read address is the next address, so rdata always matches addr_q
  kli_key_mem #(
    .DEPTH (MAX_KEYS),
    .AW    (AW)
  ) u_key_mem (
    .clk_i   (clk_i),
    .we_i    (load_we),
    .waddr_i (AW'(in_i.payload.key_index)),
    .wdata_i (wdata),
    .raddr_i (addr_d),
    .rdata_o (rdata)
  );

  assign hit      = t_q < rdata.key_time;
  assign last     = CW'(addr_q) == (n_q - CW'(1));
  assign den_zero = t1_q == t0_q;

  // ---------------------------------------------------------------- arithmetic
  kli_divider u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i ({num_mag_q, {kli_pkg::FRAC_W{1'b0}}}),
    .divisor_i  (den_mag_q),
    .busy_o     (div_busy),
    .quotient_o (quotient)
  );

  kli_lerp_unit u_lerp (
    .clk_i    (clk_i),
    .step_i   (lerp_step),
    .start_i  (start_q[comp_q]),
    .end_i    (end_q[comp_q]),
    .factor_i (mf_q),
    .fneg_i   (fneg_q),
    .res_o    (lerp_res),
    .sat_o    (lerp_sat)
  );

  // ---------------------------------------------------------------- sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      kli_pkg::S_IDLE: begin
        if (sample_fire) begin
          state_d = (n_eff == CW'(1)) ? kli_pkg::S_SINGLE : kli_pkg::S_SRCH;
        end
      end
      kli_pkg::S_SINGLE:   state_d = kli_pkg::S_EMIT;
      kli_pkg::S_SRCH: begin
        if (hit || last) begin
          state_d = kli_pkg::S_FETCH0;
        end
      end
      kli_pkg::S_FETCH0:   state_d = kli_pkg::S_FETCH1;
      kli_pkg::S_FETCH1:   state_d = kli_pkg::S_PREP;
      kli_pkg::S_PREP:     state_d = den_zero ? kli_pkg::S_EMIT : kli_pkg::S_DIV_GO;
      kli_pkg::S_DIV_GO:   state_d = kli_pkg::S_DIV_WAIT;
      kli_pkg::S_DIV_WAIT: begin
        if (!div_busy) begin
          state_d = kli_pkg::S_DELTA;
        end
      end
      kli_pkg::S_DELTA:    state_d = kli_pkg::S_MUL_HI;
      kli_pkg::S_MUL_HI:   state_d = kli_pkg::S_MUL_LO;
      kli_pkg::S_MUL_LO:   state_d = kli_pkg::S_SUM;
      kli_pkg::S_SUM:      state_d = kli_pkg::S_APPLY;
      kli_pkg::S_APPLY:    state_d = (comp_q == LAST_COMP) ? kli_pkg::S_EMIT
                                                           : kli_pkg::S_DELTA;
      kli_pkg::S_EMIT: begin
        if (out_free) begin
          state_d = kli_pkg::S_IDLE;
        end
      end
      default:             state_d = kli_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    addr_d    = addr_q;
    div_start = 1'b0;
    lerp_step = kli_pkg::LS_IDLE;
    case (state_q)
      kli_pkg::S_IDLE: begin
        if (sample_fire) begin
          addr_d = (n_eff == CW'(1)) ? '0 : AW'(1);
        end
      end
      kli_pkg::S_SRCH: begin
        // on a hit the segment starts one below; no hit falls back to slot 0
        if (hit) begin
          addr_d = addr_q - AW'(1);
        end else if (last) begin
          addr_d = '0;
        end else begin
          addr_d = addr_q + AW'(1);
        end
      end
      kli_pkg::S_FETCH0: addr_d    = seg_q + AW'(1);
      kli_pkg::S_DIV_GO: div_start = 1'b1;
      kli_pkg::S_DELTA:  lerp_step = kli_pkg::LS_DELTA;
      kli_pkg::S_MUL_HI: lerp_step = kli_pkg::LS_MUL_HI;
      kli_pkg::S_MUL_LO: lerp_step = kli_pkg::LS_MUL_LO;
      kli_pkg::S_SUM:    lerp_step = kli_pkg::LS_SUM;
      kli_pkg::S_APPLY:  lerp_step = kli_pkg::LS_APPLY;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= kli_pkg::S_IDLE;
      key_count_q <= kli_pkg::CFG_W'(1);
      addr_q      <= '0;
      comp_q      <= '0;
    end else begin
      state_q <= state_d;
      addr_q  <= addr_d;
      if (cfg_we_i) begin
        key_count_q <= cfg_wdata_i;
      end
      if (state_q == kli_pkg::S_PREP) begin
        comp_q <= '0;
      end else if (state_q == kli_pkg::S_APPLY) begin
        comp_q <= comp_q + 2'd1;
      end
    end
  end

  // ---------------------------------------------------------------- datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      kli_pkg::S_IDLE: begin
        if (sample_fire) begin
          t_q <= in_i.payload.sample_time;
          n_q <= n_eff;
        end
      end
      kli_pkg::S_SINGLE: begin
        res_q[0] <= rdata.key_x;
        res_q[1] <= rdata.key_y;
        res_q[2] <= rdata.key_z;
        seg_q    <= '0;
        status_q <= kli_pkg::STS_SINGLE;
      end
      kli_pkg::S_SRCH: begin
        if (hit || last) begin
          seg_q <= addr_d;
        end
      end
      kli_pkg::S_FETCH0: begin
        // start key doubles as the zero-length answer
        t0_q       <= rdata.key_time;
        start_q[0] <= rdata.key_x;
        start_q[1] <= rdata.key_y;
        start_q[2] <= rdata.key_z;
        res_q[0]   <= rdata.key_x;
        res_q[1]   <= rdata.key_y;
        res_q[2]   <= rdata.key_z;
      end
      kli_pkg::S_FETCH1: begin
        t1_q     <= rdata.key_time;
        end_q[0] <= rdata.key_x;
        end_q[1] <= rdata.key_y;
        end_q[2] <= rdata.key_z;
      end
      kli_pkg::S_PREP: begin
        num_mag_q <= (t_q >= t0_q) ? t_q - t0_q : t0_q - t_q;
        den_mag_q <= (t1_q >= t0_q) ? t1_q - t0_q : t0_q - t1_q;
        fneg_q    <= (t_q < t0_q) ^ (t1_q < t0_q);
        status_q  <= den_zero ? kli_pkg::STS_ZERO_LEN : kli_pkg::STS_INTERP;
      end
      kli_pkg::S_DIV_WAIT: begin
        if (!div_busy) begin
          mf_q <= quotient;
        end
      end
      kli_pkg::S_APPLY: begin
        res_q[comp_q] <= lerp_res;
        if (lerp_sat) begin
          status_q <= kli_pkg::STS_SAT;
        end
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------- result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if ((state_q == kli_pkg::S_EMIT) && out_free) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == kli_pkg::S_EMIT) && out_free) begin
      out_q.out_x   <= res_q[0];
      out_q.out_y   <= res_q[1];
      out_q.out_z   <= res_q[2];
      out_q.segment <= kli_pkg::IDX_W'(seg_q);
      out_q.status  <= status_q;
    end
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.payload = out_q;

endmodule

/* rtl/kli_checker.sv */
// kli_checker: port-level assertions for keyframe_linear_interpolator.
// Depends on kli_pkg; bound to the top level at the end of this file.
`timescale 1ns / 1ps

module kli_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_i,
  input kli_pkg::kli_op_e  in_op_i,
  input logic              out_valid_i,
  input logic              out_ready_i,
  input kli_pkg::kli_out_t out_payload_i
);

  // hold a stalled result beat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_payload_i))
    else $error("result beat dropped or changed while stalled");

  // a sample beat puts the sequencer to work
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && (in_op_i == kli_pkg::OP_SAMPLE) |=> !in_ready_i)
    else $error("input still ready right after a sample beat");

  // a load beat never produces a result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && (in_op_i == kli_pkg::OP_LOAD) |=> !$rose(out_valid_i))
    else $error("result appeared after a load beat");

  // single-key results always report segment 0
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_payload_i.status == kli_pkg::STS_SINGLE)
      |-> out_payload_i.segment == '0)
    else $error("single-key result with nonzero segment");

endmodule

bind keyframe_linear_interpolator kli_checker u_kli_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_i.valid),
  .in_ready_i    (in_i.ready),
  .in_op_i       (in_i.payload.op),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .out_payload_i (out_o.payload)
);
